// ===== hdl/double_ended_priority_queue_macros.svh =====
// Assertion macros for the double-ended priority queue checker.
// Depends on nothing; included by the checker file.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DEPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define DEPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/depq_pkg.sv =====
// Types and codes shared by the double-ended priority queue files.
// Depends on nothing.
package depq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_HI  = 2'd1,
    CMD_POP_LO  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] entry_key;
    logic [31:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped_key;
  } out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] prio;
  } entry_t;

endpackage

// ===== hdl/double_ended_priority_queue.sv =====
// Double-ended priority queue, top level.
// Depends on depq_pkg.
//
// Entries sit in one synchronous memory as a ring sorted by ascending priority, starting
// at a head pointer. One transaction is worked at a time and in_ready is high only between
// transactions. A pop steps through setting the address, reading, taking the key and
// handing off the result. A full or empty refusal and command 3 go straight to handing
// off the result. An insert scans upward from the lowest entry, reading then comparing
// each entry, until it meets a priority not below its own. It then moves every higher
// entry up one slot (read, then write back) and writes the new entry. An insert into an
// empty queue goes straight to the write. A duplicate is refused where the scan meets it.
// The single memory port pair sets this step-by-step pace. A result that has not been
// taken holds the next one back, and the block waits for it. No clearing pass after reset.
module double_ended_priority_queue #(
  parameter int CAPACITY = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  depq_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output depq_pkg::out_t   out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b0_0000_0001,
    S_SCAN_RD  = 9'b0_0000_0010,
    S_SCAN_CMP = 9'b0_0000_0100,
    S_SHIFT_RD = 9'b0_0000_1000,
    S_SHIFT_WR = 9'b0_0001_0000,
    S_INS_WR   = 9'b0_0010_0000,
    S_POP_WAIT = 9'b0_0100_0000,
    S_DONE     = 9'b0_1000_0000,
    S_POP_RD   = 9'b1_0000_0000
  } state_t;

  depq_pkg::entry_t mem [CAPACITY];
  depq_pkg::entry_t rd_data_r;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [31:0]       prio_r, prio_nxt;
  depq_pkg::out_t    res_r, res_nxt;
  depq_pkg::out_t    out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  depq_pkg::entry_t  wr_data;

  // Map a logical position onto the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(i);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign rd_addr = phys(head_r, idx_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    prio_nxt      = prio_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = phys(head_r, pos_r);
    wr_data       = '{key: key_r, prio: prio_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          key_nxt  = in_data.entry_key;
          prio_nxt = in_data.priority_req;
          res_nxt  = '{status: depq_pkg::ST_OK, popped_key: 32'd0};
          state_nxt = S_DONE;
          unique case (in_data.command)
            depq_pkg::CMD_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                res_nxt.status = depq_pkg::ST_FULL;
              end else if (count_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_INS_WR;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            depq_pkg::CMD_POP_HI, depq_pkg::CMD_POP_LO: begin
              if (count_r == '0) begin
                res_nxt.status = depq_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = (in_data.command == depq_pkg::CMD_POP_HI) ? count_r - 1'b1 : '0;
                state_nxt = S_POP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (rd_data_r.prio == prio_r) begin
          res_nxt.status = depq_pkg::ST_DUP;
          state_nxt      = S_DONE;
        end else if (rd_data_r.prio > prio_r) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r - 1'b1;
          state_nxt = S_SHIFT_RD;
        end else if (idx_r + 1'b1 == count_r) begin
          pos_nxt   = count_r;
          state_nxt = S_INS_WR;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        // Move one entry up a slot, walking down toward the insert point.
        wr_en   = 1'b1;
        wr_addr = phys(head_r, idx_r + 1'b1);
        wr_data = rd_data_r;
        if (idx_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_SHIFT_RD;
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_POP_RD: state_nxt = S_POP_WAIT;
      S_POP_WAIT: begin
        res_nxt.popped_key = rd_data_r.key;
        count_nxt          = count_r - 1'b1;
        if (cmd_r == depq_pkg::CMD_POP_LO) begin
          head_nxt = phys(head_r, CW'(1));
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    prio_r <= prio_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== hdl/depq_checker.sv =====
// Port-level checks for the double-ended priority queue, with the bind to the top level.
// Depends on depq_pkg and double_ended_priority_queue_macros.svh.
`include "double_ended_priority_queue_macros.svh"

module depq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input depq_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input depq_pkg::out_t out_data
);

  `DEPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `DEPQ_ASSERT_NOW(a_fail_key_zero, clk, rst_n, out_valid && (out_data.status != depq_pkg::ST_OK), out_data.popped_key == 32'd0, "refused transaction carries a key")
  `DEPQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "accepted a transaction while one is in work")

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_top.sv =====
// Testbench for the double-ended priority queue: directed and random commands,
// checked against a sorted-list predictor. Depends on depq_pkg and the DUT.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 256;
  localparam int CYCLE_LIMIT = 3000000;

  class depq_scoreboard;
    logic [31:0]     keys[$];
    logic [31:0]     prios[$];
    depq_pkg::out_t  pending[$];
    int              errors;
    int              n_ok_pop, n_empty, n_full, n_dup, n_ins;

    function void note_command(depq_pkg::in_t t);
      depq_pkg::out_t r;
      int   pos;
      r.status     = depq_pkg::ST_OK;
      r.popped_key = '0;
      case (depq_pkg::cmd_t'(t.command))
        depq_pkg::CMD_INSERT: begin
          if (prios.size() >= CAP) begin
            r.status = depq_pkg::ST_FULL;
            n_full++;
          end else begin
            pos = 0;
            while (pos < prios.size() && prios[pos] < t.priority_req) pos++;
            if (pos < prios.size() && prios[pos] == t.priority_req) begin
              r.status = depq_pkg::ST_DUP;
              n_dup++;
            end else begin
              prios.insert(pos, t.priority_req);
              keys.insert(pos, t.entry_key);
              n_ins++;
            end
          end
        end
        depq_pkg::CMD_POP_HI, depq_pkg::CMD_POP_LO: begin
          if (prios.size() == 0) begin
            r.status = depq_pkg::ST_EMPTY;
            n_empty++;
          end else if (depq_pkg::cmd_t'(t.command) == depq_pkg::CMD_POP_HI) begin
            r.popped_key = keys.pop_back();
            void'(prios.pop_back());
            n_ok_pop++;
          end else begin
            r.popped_key = keys.pop_front();
            void'(prios.pop_front());
            n_ok_pop++;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(depq_pkg::out_t got);
      depq_pkg::out_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d key=%h",
                                   got.status, got.popped_key);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.popped_key !== exp.popped_key) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp status=%0d key=%h got status=%0d key=%h",
                   exp.status, exp.popped_key, got.status, got.popped_key);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  depq_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  depq_pkg::out_t out_data;

  depq_scoreboard sb = new();
  int   cycles = 0;
  int   stall_mode = 0;
  logic [31:0] prio_pool[$];

  double_ended_priority_queue #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: no-stall, random-stall and periodic-stall-window modes, switched at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((cycles % 7) < 3);
    endcase
    if ((cycles % 500) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // hold valid after the accept; the caller drops it before any gap
  task automatic send(input depq_pkg::cmd_t c, input logic [31:0] k,
                      input logic [31:0] p);
    depq_pkg::in_t t;
    t.command      = c;
    t.entry_key    = k;
    t.priority_req = p;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_command(t);
  endtask

  // sender: random bursts, random gaps
  int burst_left = 0;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_prio();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return (prio_pool.size() != 0) ?
                prio_pool[$urandom_range(0, prio_pool.size() - 1)] : $urandom();
      default: return $urandom();
    endcase
  endfunction

  task automatic random_cmd(input int ins_weight);
    logic [31:0] p;
    int r;
    r = $urandom_range(0, 99);
    pace();
    if (r < ins_weight) begin
      p = pick_prio();
      if (prio_pool.size() < 64) prio_pool.push_back(p);
      send(depq_pkg::CMD_INSERT, $urandom(), p);
    end else if (r < ins_weight + (97 - ins_weight) / 2)
      send(depq_pkg::CMD_POP_HI, $urandom(), $urandom());
    else if (r < 97)
      send(depq_pkg::CMD_POP_LO, $urandom(), $urandom());
    else
      send(depq_pkg::CMD_NOP, $urandom(), $urandom());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, extremes, duplicate, nop, ordering
    send(depq_pkg::CMD_POP_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(depq_pkg::CMD_POP_LO, 32'h0, 32'h0);
    send(depq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send(depq_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send(depq_pkg::CMD_INSERT, 32'hA5A5_5A5A, 32'h8000_0000);
    send(depq_pkg::CMD_INSERT, 32'h1234_5678, 32'h8000_0000);
    send(depq_pkg::CMD_INSERT, 32'h5555_AAAA, 32'h7FFF_FFFF);
    send(depq_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(depq_pkg::CMD_POP_HI, 0, 0);
    send(depq_pkg::CMD_POP_LO, 0, 0);
    send(depq_pkg::CMD_POP_HI, 0, 0);
    send(depq_pkg::CMD_POP_LO, 0, 0);
    send(depq_pkg::CMD_POP_LO, 0, 0);
    send(depq_pkg::CMD_POP_HI, 0, 0);
    drain();

    // fill to capacity, full refusals (one also a duplicate), then pop it empty and past
    for (int i = 0; i < CAP; i++) send(depq_pkg::CMD_INSERT, $urandom(), i * 3 + 1);
    send(depq_pkg::CMD_INSERT, 32'hDEAD_BEEF, 32'h0000_0004);
    send(depq_pkg::CMD_INSERT, 32'hDEAD_BEEF, 32'h0000_0002);
    for (int i = 0; i < CAP + 2; i++)
      send(($urandom_range(0, 1) != 0) ? depq_pkg::CMD_POP_HI : depq_pkg::CMD_POP_LO,
           0, 0);
    drain();

    // random: mostly small queues, with one growth phase
    for (int i = 0; i < 550; i++) random_cmd(i < 275 ? 50 : (i < 440 ? 70 : 35));
    drain();
    for (int i = 0; i < 250; i++) random_cmd(48);
    drain();

    repeat (50) @(posedge clk);
    $display("covered %0d inserts, %0d pops, %0d empty pops, %0d full, %0d duplicates",
             sb.n_ins, sb.n_ok_pop, sb.n_empty, sb.n_full, sb.n_dup);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
